[rtl/core/tde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tde_pkg
// Shared widths, types and helpers of the trajectory displacement error block.
// ----------------------------------------------------------------------------
package tde_pkg;

  localparam int unsigned COORD_W        = 24;
  localparam int unsigned DIFF_W         = COORD_W + 1;
  localparam int unsigned SQ_W           = 2 * DIFF_W;
  localparam int unsigned ROOT_W         = SQ_W / 2;
  localparam int unsigned DIST_W         = 26;
  localparam int unsigned SUM_W          = 36;
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned CNT_LIMIT      = 2047;
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned AXES           = 3;
  localparam int unsigned AXIS_W         = 2;
  localparam int unsigned SQRT_STEPS     = ROOT_W;
  localparam int unsigned SQRT_STEP_W    = $clog2(SQRT_STEPS);
  localparam int unsigned DIV_STEPS      = SUM_W;
  localparam int unsigned DIV_STEP_W     = $clog2(DIV_STEPS);
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  // One pair after the front end: exact sum of squared axis differences.
  typedef struct packed {
    logic [SQ_W-1:0] sq_sum;
    logic            last;
  } pair_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQRT,
    B_ACC,
    B_DIV,
    B_EMIT
  } back_state_e;

  // Number of pairs that may be counted, kept within the counter range.
  function automatic int unsigned capacity(input int unsigned max_points);
    int unsigned c;
    c = max_points;
    if (c > CNT_LIMIT) c = CNT_LIMIT;
    if (c < 1) c = 1;
    return c;
  endfunction

endpackage

[rtl/core/tde_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tde_front
// Takes a point pair, forms the axis differences and sums their squares with
// one shared multiplier, then hands the sum to the queue.
// ----------------------------------------------------------------------------
module tde_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [tde_pkg::COORD_W-1:0]       pred_x_i,
  input  logic [tde_pkg::COORD_W-1:0]       pred_y_i,
  input  logic [tde_pkg::COORD_W-1:0]       pred_z_i,
  input  logic [tde_pkg::COORD_W-1:0]       act_x_i,
  input  logic [tde_pkg::COORD_W-1:0]       act_y_i,
  input  logic [tde_pkg::COORD_W-1:0]       act_z_i,
  input  logic                              last_i,
  output logic                              push_valid_o,
  input  logic                              push_stall_i,
  output tde_pkg::pair_t                    push_data_o
);

  tde_pkg::front_state_e state_q, state_d;
  logic [tde_pkg::AXIS_W-1:0] idx_q, idx_d;
  logic [tde_pkg::DIFF_W-1:0] mag_q [tde_pkg::AXES];
  logic [tde_pkg::DIFF_W-1:0] mag_d [tde_pkg::AXES];
  logic [tde_pkg::SQ_W-1:0]   acc_q, acc_d;
  logic                       last_q;
  logic [tde_pkg::SQ_W-1:0]   prod;
  logic                       accept;

  logic signed [tde_pkg::DIFF_W-1:0] diff [tde_pkg::AXES];

  assign diff[0] = $signed({pred_x_i[tde_pkg::COORD_W-1], pred_x_i})
                 - $signed({act_x_i[tde_pkg::COORD_W-1], act_x_i});
  assign diff[1] = $signed({pred_y_i[tde_pkg::COORD_W-1], pred_y_i})
                 - $signed({act_y_i[tde_pkg::COORD_W-1], act_y_i});
  assign diff[2] = $signed({pred_z_i[tde_pkg::COORD_W-1], pred_z_i})
                 - $signed({act_z_i[tde_pkg::COORD_W-1], act_z_i});

  // Magnitude of -2^24 is 2^24, still inside the unsigned width.
  always_comb begin
    for (int i = 0; i < tde_pkg::AXES; i++) begin
      mag_d[i] = diff[i][tde_pkg::DIFF_W-1] ? (~diff[i] + 1'b1) : diff[i];
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign prod   = mag_q[idx_q] * mag_q[idx_q];

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    acc_d        = acc_q;
    in_stall_o   = 1'b1;
    push_valid_o = 1'b0;
    unique case (state_q)
      tde_pkg::F_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          idx_d   = '0;
          acc_d   = '0;
          state_d = tde_pkg::F_MUL;
        end
      end
      tde_pkg::F_MUL: begin
        acc_d = acc_q + prod;
        idx_d = idx_q + 1'b1;
        if (idx_q == tde_pkg::AXIS_W'(tde_pkg::AXES - 1)) begin
          state_d = tde_pkg::F_PUSH;
        end
      end
      tde_pkg::F_PUSH: begin
        push_valid_o = 1'b1;
        if (!push_stall_i) begin
          state_d = tde_pkg::F_IDLE;
        end
      end
      default: state_d = tde_pkg::F_IDLE;
    endcase
  end

  assign push_data_o = '{sq_sum: acc_q, last: last_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tde_pkg::F_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (accept) begin
      mag_q  <= mag_d;
      last_q <= last_i;
    end
  end

endmodule

[rtl/core/tde_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tde_queue
// Short first-in first-out queue of pair sums between front and back end.
// ----------------------------------------------------------------------------
module tde_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_stall_o,
  input  tde_pkg::pair_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_stall_i,
  output tde_pkg::pair_t pop_data_o
);

  tde_pkg::pair_t              entries_q [tde_pkg::QUEUE_DEPTH];
  logic [tde_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
  logic [tde_pkg::QCNT_W-1:0]  cnt_q;
  logic                        push, pop;

  assign push_stall_o = (cnt_q == tde_pkg::QCNT_W'(tde_pkg::QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entries_q[rptr_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wptr_q] <= push_data_i;
  end

endmodule

[rtl/core/tde_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tde_back
// Iterative square root per pair, running sum and count, and an iterative
// divider for the mean on the final pair. Holds the result register.
// ----------------------------------------------------------------------------
module tde_back #(
  parameter int unsigned MAX_POINTS = tde_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  output logic                         pop_stall_o,
  input  tde_pkg::pair_t               pop_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tde_pkg::DIST_W-1:0]   ade_o,
  output logic [tde_pkg::DIST_W-1:0]   fde_o,
  output logic [tde_pkg::CNT_W-1:0]    pair_count_o,
  output logic                         overflow_o
);

  localparam int unsigned Cap = tde_pkg::capacity(MAX_POINTS);
  localparam int unsigned RemW = tde_pkg::ROOT_W + 2;

  tde_pkg::back_state_e state_q, state_d;

  // square root unit
  logic [tde_pkg::SQ_W-1:0]        rad_q, rad_d;
  logic [RemW-1:0]                 rem_q, rem_d;
  logic [tde_pkg::ROOT_W-1:0]      root_q, root_d;
  logic [tde_pkg::SQRT_STEP_W-1:0] sstep_q, sstep_d;
  logic [RemW+1:0]                 rem_shift, trial;
  logic                            sq_ge;
  logic                            last_q, last_d;

  // running state
  logic [tde_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic [tde_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic [tde_pkg::DIST_W-1:0]      recent_q, recent_d;
  logic                            ovf_q, ovf_d;
  logic [tde_pkg::SUM_W:0]         sum_ext;
  logic                            room;

  // divider unit
  logic [tde_pkg::SUM_W-1:0]       dvd_q, dvd_d;
  logic [tde_pkg::CNT_W-1:0]       drem_q, drem_d;
  logic [tde_pkg::DIV_STEP_W-1:0]  dstep_q, dstep_d;
  logic [tde_pkg::CNT_W:0]         div_shift;
  logic                            div_ge;

  // result register
  logic                            out_valid_q, out_valid_d;
  logic                            load_out;

  assign rem_shift = {rem_q, rad_q[tde_pkg::SQ_W-1 -: 2]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign sq_ge     = (rem_shift >= trial);

  assign room      = (cnt_q < tde_pkg::CNT_W'(Cap));
  assign sum_ext   = {1'b0, sum_q} + (tde_pkg::SUM_W + 1)'(root_q);

  assign div_shift = {drem_q, dvd_q[tde_pkg::SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, cnt_q});

  always_comb begin
    state_d     = state_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    sstep_d     = sstep_q;
    last_d      = last_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    recent_d    = recent_q;
    ovf_d       = ovf_q;
    dvd_d       = dvd_q;
    drem_d      = drem_q;
    dstep_d     = dstep_q;
    pop_stall_o = 1'b1;
    load_out    = 1'b0;
    unique case (state_q)
      tde_pkg::B_IDLE: begin
        pop_stall_o = 1'b0;
        if (pop_valid_i) begin
          rad_d   = pop_data_i.sq_sum;
          last_d  = pop_data_i.last;
          rem_d   = '0;
          root_d  = '0;
          sstep_d = '0;
          state_d = tde_pkg::B_SQRT;
        end
      end
      tde_pkg::B_SQRT: begin
        rem_d   = sq_ge ? RemW'(rem_shift - trial) : RemW'(rem_shift);
        root_d  = {root_q[tde_pkg::ROOT_W-2:0], sq_ge};
        rad_d   = {rad_q[tde_pkg::SQ_W-3:0], 2'b00};
        sstep_d = sstep_q + 1'b1;
        if (sstep_q == tde_pkg::SQRT_STEP_W'(tde_pkg::SQRT_STEPS - 1)) begin
          state_d = tde_pkg::B_ACC;
        end
      end
      tde_pkg::B_ACC: begin
        if (room) begin
          // saturate the running sum
          sum_d    = sum_ext[tde_pkg::SUM_W] ? '1 : sum_ext[tde_pkg::SUM_W-1:0];
          cnt_d    = cnt_q + 1'b1;
          recent_d = tde_pkg::DIST_W'(root_q);
        end else begin
          ovf_d = 1'b1;
        end
        dvd_d   = sum_d;
        drem_d  = '0;
        dstep_d = '0;
        state_d = last_q ? tde_pkg::B_DIV : tde_pkg::B_IDLE;
      end
      tde_pkg::B_DIV: begin
        drem_d  = div_ge ? tde_pkg::CNT_W'(div_shift - {1'b0, cnt_q})
                         : tde_pkg::CNT_W'(div_shift);
        dvd_d   = {dvd_q[tde_pkg::SUM_W-2:0], div_ge};
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == tde_pkg::DIV_STEP_W'(tde_pkg::DIV_STEPS - 1)) begin
          state_d = tde_pkg::B_EMIT;
        end
      end
      tde_pkg::B_EMIT: begin
        // wait for the result register to free up, then clear the totals
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          sum_d    = '0;
          cnt_d    = '0;
          recent_d = '0;
          ovf_d    = 1'b0;
          state_d  = tde_pkg::B_IDLE;
        end
      end
      default: state_d = tde_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tde_pkg::B_IDLE;
      sstep_q     <= '0;
      dstep_q     <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      recent_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sstep_q     <= sstep_d;
      dstep_q     <= dstep_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      recent_q    <= recent_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    last_q <= last_d;
    dvd_q  <= dvd_d;
    drem_q <= drem_d;
    if (load_out) begin
      ade_o        <= (cnt_q == '0) ? '0 : dvd_q[tde_pkg::DIST_W-1:0];
      fde_o        <= recent_q;
      pair_count_o <= cnt_q;
      overflow_o   <= ovf_q;
    end
  end

endmodule

[rtl/core/trajectory_displacement_error.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_displacement_error
// Average and final displacement error over a stream of predicted/actual
// point pairs; one result per trajectory on the pair marked last.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o  | pred_x/y/z, act_x/y/z, last
//  out     | output    | out_valid_o / out_stall_i| ade, fde, pair_count, overflow
//
//  The front end accepts a pair, forms the three squares in turn on one
//  multiplier and hands the sum off before it takes the next pair. The back
//  end runs a 25-step square root per pair; a last pair adds the divide and
//  the load of the result. A two-entry queue between the parts absorbs the difference in pace.
//  Reset is asynchronous, active low, and clears all totals; no clearing pass.
//  A stalled result holds in its register while the next pairs are summed.
// ----------------------------------------------------------------------------
module trajectory_displacement_error #(
  parameter int unsigned MAX_POINTS = tde_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tde_pkg::COORD_W-1:0]  pred_x_i,
  input  logic [tde_pkg::COORD_W-1:0]  pred_y_i,
  input  logic [tde_pkg::COORD_W-1:0]  pred_z_i,
  input  logic [tde_pkg::COORD_W-1:0]  act_x_i,
  input  logic [tde_pkg::COORD_W-1:0]  act_y_i,
  input  logic [tde_pkg::COORD_W-1:0]  act_z_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tde_pkg::DIST_W-1:0]   ade_o,
  output logic [tde_pkg::DIST_W-1:0]   fde_o,
  output logic [tde_pkg::CNT_W-1:0]    pair_count_o,
  output logic                         overflow_o
);

  localparam int unsigned Cap = tde_pkg::capacity(MAX_POINTS);

  logic           push_valid, push_stall;
  tde_pkg::pair_t push_data;
  logic           pop_valid, pop_stall;
  tde_pkg::pair_t pop_data;

  tde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pred_x_i     (pred_x_i),
    .pred_y_i     (pred_y_i),
    .pred_z_i     (pred_z_i),
    .act_x_i      (act_x_i),
    .act_y_i      (act_y_i),
    .act_z_i      (act_z_i),
    .last_i       (last_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_data_o  (push_data)
  );

  tde_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_data_o   (pop_data)
  );

  tde_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_stall_o  (pop_stall),
    .pop_data_i   (pop_data),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ade_o        (ade_o),
    .fde_o        (fde_o),
    .pair_count_o (pair_count_o),
    .overflow_o   (overflow_o)
  );

  // A result always covers at least one counted pair and never exceeds capacity.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pair_count_o != '0) && (pair_count_o <= tde_pkg::CNT_W'(Cap)))
    else $error("pair count out of range");

  // Distances stay below 2^25, so the mean does too.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !ade_o[tde_pkg::DIST_W-1] && !fde_o[tde_pkg::DIST_W-1])
    else $error("distance out of range");

  // The front end is busy right after each transfer in.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front end took a second pair too early");

endmodule
